// ===== hdl/swm_pkg.sv =====
// Shared types and constants of the sliding window median filter.
// No dependencies; every other file imports this package.
package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SIZE_W     = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W      = $clog2(WINDOW_MAX);
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int SAMPLE_W   = 32;
  localparam int MEDIAN_W   = SAMPLE_W + 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  localparam logic [SIZE_W-1:0] WINDOW_SIZE_RESET = SIZE_W'(3);
  localparam logic              REG_WINDOW_SIZE   = 1'b0;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_AGE,
    OP_SHIFT,
    OP_INSERT
  } swm_op_t;

  typedef struct packed {
    swm_op_t                    op;
    logic                       first;
    logic [SIZE_W-1:0]          k;
    logic signed [SAMPLE_W-1:0] sample;
  } swm_ctrl_t;

  typedef struct packed {
    logic                       vld;
    logic [AGE_W-1:0]           age;
    logic signed [SAMPLE_W-1:0] value;
  } swm_entry_t;

endpackage

// ===== hdl/swm_cell.sv =====
// One slot of the sorted window: holds a sample, its age and a valid bit.
// Depends on swm_pkg; instantiated by swm_chain.
module swm_cell import swm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  swm_ctrl_t  ctrl,
  input  logic       shift_en,
  input  swm_entry_t upper,
  input  swm_entry_t lower,
  input  logic       lower_keep,
  output swm_entry_t entry,
  output logic       keep
);

  swm_entry_t        entry_r;
  swm_entry_t        entry_nxt;
  logic [SIZE_W-1:0] age_inc;
  logic              live;

  assign age_inc = {1'b0, entry_r.age} + SIZE_W'(1);
  assign live    = entry_r.vld && !ctrl.first && (age_inc < ctrl.k);
  assign keep    = entry_r.vld && ($signed(entry_r.value) <= $signed(ctrl.sample));
  assign entry   = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      OP_AGE: begin
        entry_nxt.vld = live;
        entry_nxt.age = age_inc[AGE_W-1:0];
      end
      OP_SHIFT: begin
        if (shift_en) begin
          entry_nxt = upper;
        end
      end
      OP_INSERT: begin
        if (!keep) begin
          if (lower_keep) begin
            entry_nxt.vld   = 1'b1;
            entry_nxt.age   = '0;
            entry_nxt.value = ctrl.sample;
          end else begin
            entry_nxt = lower;
          end
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.vld <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ===== hdl/swm_chain.sv =====
// Row of WINDOW_MAX cells kept in ascending order, lowest value in cell 0.
// Depends on swm_pkg and swm_cell; works out the compaction mask.
module swm_chain import swm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swm_ctrl_t                  ctrl,
  output logic [WINDOW_MAX-1:0]      vld,
  output logic                       packed_ok,
  output logic signed [SAMPLE_W-1:0] values [WINDOW_MAX]
);

  swm_entry_t            entries [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] keeps;
  logic [WINDOW_MAX-1:0] vld_inc;
  logic [WINDOW_MAX-1:0] first_hole;
  logic [WINDOW_MAX-1:0] shift_mask;

  assign vld_inc    = vld + WINDOW_MAX'(1);
  assign first_hole = vld_inc & ~vld;
  assign shift_mask = ~first_hole + WINDOW_MAX'(1);
  assign packed_ok  = (vld & vld_inc) == '0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_entry_t up_entry;
    swm_entry_t lo_entry;
    logic       lo_keep;

    if (i == WINDOW_MAX - 1) begin : g_top
      assign up_entry = '0;
    end else begin : g_mid
      assign up_entry = entries[i+1];
    end

    if (i == 0) begin : g_bot
      assign lo_entry = '0;
      assign lo_keep  = 1'b1;
    end else begin : g_low
      assign lo_entry = entries[i-1];
      assign lo_keep  = keeps[i-1];
    end

    swm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .shift_en   (shift_mask[i]),
      .upper      (up_entry),
      .lower      (lo_entry),
      .lower_keep (lo_keep),
      .entry      (entries[i]),
      .keep       (keeps[i])
    );

    assign vld[i]    = entries[i].vld;
    assign values[i] = entries[i].value;
  end

endmodule

// ===== hdl/sliding_window_median.sv =====
// Top level of the sliding window median filter: stream ports, APB register,
// sequencer and output register. Depends on swm_pkg and swm_chain.
//
//   channel | dir | handshake         | payload
//   in      | in  | in_tvalid/tready  | tdata sample, tuser first
//   out     | out | out_tvalid/tready | tdata median_twice
//   cfg     | in  | psel/penable      | window_size at byte address 0
//
// From a sample's transfer to the next one the sequencer runs age and drop,
// compaction, insert, pick the middle cells, then, with a full window, load the sum into out_tdata.
// Compaction shifts the row down past each dropped entry below a kept one.
// rst_n is synchronous; it clears the valid bits of all cells at once.
// A result waiting in the output register stalls the sequencer only at the sum.
module sliding_window_median import swm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] sample
  input  logic                  in_tuser,   // [0] first
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [32:0] median_twice, zero fill above
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PACK = 4'b0010,
    ST_PICK = 4'b0100,
    ST_EMIT = 4'b1000
  } swm_state_t;

  swm_state_t                 state_r, state_nxt;
  logic [SIZE_W-1:0]          window_size_r;
  logic [SIZE_W-1:0]          k_eff;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] mid_a_r, mid_b_r;
  logic                       full_r;
  logic                       out_tvalid_r;
  logic [MEDIAN_W-1:0]        out_data_r;
  logic [IDX_W-1:0]           idx_hi, idx_lo, idx_full;
  logic [MEDIAN_W-1:0]        sum;
  logic                       in_xfer, out_xfer, out_load, cfg_wr;
  swm_ctrl_t                  ctrl;
  logic [WINDOW_MAX-1:0]      vld;
  logic                       packed_ok;
  logic signed [SAMPLE_W-1:0] values [WINDOW_MAX];

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? {{(CFG_DW-SIZE_W){1'b0}}, window_size_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_wr) begin
      window_size_r <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (window_size_r == '0) begin
      k_eff = SIZE_W'(1);
    end else if (window_size_r > SIZE_W'(WINDOW_MAX)) begin
      k_eff = SIZE_W'(WINDOW_MAX);
    end else begin
      k_eff = window_size_r;
    end
  end

  assign idx_hi   = k_eff[SIZE_W-1:1];
  assign idx_lo   = k_eff[0] ? idx_hi : idx_hi - IDX_W'(1);
  assign idx_full = IDX_W'(k_eff - SIZE_W'(1));

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid_r && out_tready;
  assign out_load  = (state_r == ST_EMIT) && full_r && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt   = state_r;
    ctrl.op     = OP_HOLD;
    ctrl.first  = in_tuser;
    ctrl.k      = k_eff;
    ctrl.sample = sample_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctrl.op   = OP_AGE;
          state_nxt = ST_PACK;
        end
      end
      ST_PACK: begin
        if (packed_ok) begin
          ctrl.op   = OP_INSERT;
          state_nxt = ST_PICK;
        end else begin
          ctrl.op = OP_SHIFT;
        end
      end
      ST_PICK: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!full_r || out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  swm_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .vld       (vld),
    .packed_ok (packed_ok),
    .values    (values)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_r <= $signed(in_tdata[SAMPLE_W-1:0]);
    end
    if (state_r == ST_PICK) begin
      mid_a_r <= values[idx_lo];
      mid_b_r <= values[idx_hi];
      full_r  <= vld[idx_full];
    end
  end

  assign sum = {mid_a_r[SAMPLE_W-1], mid_a_r} + {mid_b_r[SAMPLE_W-1], mid_b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_xfer) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= sum;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-MEDIAN_W){1'b0}}, out_data_r};

`ifndef SYNTHESIS
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while a sample is in work");

  a_window_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ((vld & (vld + WINDOW_MAX'(1))) == '0))
    else $error("cell row has a hole while idle");

  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped or changed while stalled");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sliding_window_median: streams samples through
// the filter under random idling and checks every median against a predictor.
// Depends on swm_pkg and the sliding_window_median RTL.
module tb import swm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RAND_PHASES   = 24;
  localparam int PHASE_ITEMS   = 50;
  localparam logic [CFG_AW-1:0] WINDOW_SIZE_ADDR = CFG_AW'(4 * int'(REG_WINDOW_SIZE));
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [31:0] sample
  logic                  in_tuser   = 1'b0; // [0] first
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [32:0] median_twice, [39:33] zero fill
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_AW-1:0]     paddr      = '0;
  logic [CFG_DW-1:0]     pwdata     = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  logic signed [SAMPLE_W-1:0] win_val [WINDOW_MAX];
  int unsigned                win_age [WINDOW_MAX];
  int unsigned                win_fill = 0;
  logic [SIZE_W-1:0]          size_reg = WINDOW_SIZE_RESET;

  logic signed [MEDIAN_W-1:0] median_q [$];
  int  errors      = 0;
  int  cycle_count = 0;
  int  next_gap    = 0;
  bit  valid_held  = 1'b0;
  bit  calm        = 1'b0;

  sliding_window_median u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_median regression: fail");
      $finish;
    end
  end

  function automatic bit predict_median(input logic signed [SAMPLE_W-1:0] s, input logic f,
                                        output logic signed [MEDIAN_W-1:0] med);
    int unsigned k, kept, pos, i;
    longint sum;
    k = (size_reg == 0) ? 1 : ((size_reg > WINDOW_MAX) ? WINDOW_MAX : int'(size_reg));
    if (f)
      win_fill = 0;
    kept = 0;
    for (i = 0; i < win_fill; i++) begin
      if (win_age[i] + 1 < k) begin
        win_val[kept] = win_val[i];
        win_age[kept] = win_age[i] + 1;
        kept++;
      end
    end
    pos = 0;
    while (pos < kept && win_val[pos] <= s)
      pos++;
    for (i = kept; i > pos; i--) begin
      win_val[i] = win_val[i-1];
      win_age[i] = win_age[i-1];
    end
    win_val[pos] = s;
    win_age[pos] = 0;
    win_fill = kept + 1;
    med = '0;
    if (win_fill != k)
      return 1'b0;
    if (k % 2 == 1)
      sum = 2 * longint'(win_val[k/2]);
    else
      sum = longint'(win_val[k/2-1]) + longint'(win_val[k/2]);
    med = sum[MEDIAN_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic f);
    logic signed [MEDIAN_W-1:0] med;
    if (next_gap > 0)
      repeat (next_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    if (predict_median(s, f, med))
      median_q = {median_q, med};
    next_gap = calm ? 0 : $urandom_range(0, 10);
    valid_held = (next_gap == 0);
    if (next_gap > 0)
      in_tvalid <= 1'b0;
  endtask

  task automatic settle_idle();
    if (valid_held) begin
      in_tvalid <= 1'b0;
      valid_held = 1'b0;
    end
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_size(input logic [SIZE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_SIZE_ADDR;
    pwdata  <= CFG_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_reg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(v)) begin
      $error("window_size: expected %0d, got %0d", v, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_window();
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
  endtask

  task automatic test_size_extremes();
    settle_idle();
    write_window_size('0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    settle_idle();
    write_window_size(SIZE_W'(2));
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    settle_idle();
    write_window_size('1);
    send_sample(32'sd7, 1'b0);
    send_sample(-32'sd7, 1'b0);
  endtask

  task automatic test_size_change();
    settle_idle();
    write_window_size(SIZE_W'(5));
    send_sample(32'sd10, 1'b1);
    send_sample(32'sd20, 1'b0);
    send_sample(32'sd30, 1'b0);
    send_sample(32'sd40, 1'b0);
    send_sample(32'sd50, 1'b0);
    settle_idle();
    write_window_size(SIZE_W'(2));
    send_sample(32'sd60, 1'b0);
    settle_idle();
    write_window_size(SIZE_W'(4));
    send_sample(32'sd70, 1'b0);
    send_sample(32'sd80, 1'b0);
  endtask

  task automatic test_first_restart();
    send_sample(-32'sd5, 1'b1);
    send_sample(32'sd3, 1'b0);
    send_sample(-32'sd9, 1'b0);
    send_sample(32'sd4, 1'b0);
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] sz;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_idle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: sz = SIZE_W'($urandom_range(1, 8));
        7:                   sz = SIZE_W'($urandom_range(9, WINDOW_MAX));
        8:                   sz = (ph % 2 == 0) ? SIZE_W'(WINDOW_MAX) : SIZE_W'($urandom_range(65, 127));
        default:             sz = SIZE_W'($urandom_range(0, 127));
      endcase
      write_window_size(sz);
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(rand_sample(), $urandom_range(0, 63) == 0);
    end
    calm = 1'b0;
  endtask

  initial begin
    int rx_gap;
    logic signed [MEDIAN_W-1:0] want;
    logic signed [MEDIAN_W-1:0] got;
    wait (rst_n === 1'b1);
    forever begin
      rx_gap = calm ? 0 : $urandom_range(0, 10);
      if (rx_gap > 0) begin
        out_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = out_tdata[MEDIAN_W-1:0];
      if (median_q.size() == 0) begin
        $error("median_twice: no transfer expected, got %0d", got);
        errors++;
      end else begin
        want = median_q.pop_front();
        if (got !== want) begin
          $error("median_twice: expected %0d, got %0d", want, got);
          errors++;
        end
        if (out_tdata[OUT_DATA_W-1:MEDIAN_W] !== '0) begin
          $error("tdata zero fill: expected 0, got %0h", out_tdata[OUT_DATA_W-1:MEDIAN_W]);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_window();
    test_size_extremes();
    test_size_change();
    test_first_restart();
    test_random_phases();
    settle_idle();
    if (errors == 0)
      $display("sliding_window_median regression: pass");
    else
      $display("sliding_window_median regression: fail");
    $finish;
  end

endmodule
